@@ design/crb_pkg.sv @@
// Shared constants, types and helpers of the CMOS clock and NVRAM register block.
`default_nettype none

package crb_pkg;

	// Sizing
	localparam int RAM_DEPTH        = 128;
	localparam int TICKS_PER_UPDATE = 100;
	localparam int IDX_W            = 7;
	localparam int CTL_COUNT        = 14;
	localparam int CTL_AW           = $clog2(CTL_COUNT);
	localparam int MEM_DEPTH        = RAM_DEPTH - CTL_COUNT;
	localparam int MEM_AW           = $clog2(MEM_DEPTH);
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 7;

	localparam logic [IDX_W:0]   RAM_DEPTH_X   = (IDX_W + 1)'(RAM_DEPTH);
	localparam logic [IDX_W-1:0] CTL_COUNT_IDX = IDX_W'(CTL_COUNT);
	localparam logic [6:0]       TICKS_LIMIT   = 7'(TICKS_PER_UPDATE);

	// Transaction kinds
	localparam logic [2:0] MODE_PORT_READ  = 3'd0;
	localparam logic [2:0] MODE_PORT_WRITE = 3'd1;
	localparam logic [2:0] MODE_PERIODIC   = 3'd2;
	localparam logic [2:0] MODE_CENTI_TICK = 3'd3;
	localparam logic [2:0] MODE_UPDATE_END = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MASK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NMI_UPDATE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_SYNC   = 2'd2;

	// Register addresses
	localparam logic [IDX_W-1:0] REG_SEC       = 7'h00;
	localparam logic [IDX_W-1:0] REG_SEC_ALM   = 7'h01;
	localparam logic [IDX_W-1:0] REG_MIN       = 7'h02;
	localparam logic [IDX_W-1:0] REG_MIN_ALM   = 7'h03;
	localparam logic [IDX_W-1:0] REG_HOUR      = 7'h04;
	localparam logic [IDX_W-1:0] REG_HOUR_ALM  = 7'h05;
	localparam logic [IDX_W-1:0] REG_A         = 7'h0A;
	localparam logic [IDX_W-1:0] REG_B         = 7'h0B;
	localparam logic [IDX_W-1:0] REG_C         = 7'h0C;
	localparam logic [IDX_W-1:0] REG_D         = 7'h0D;
	localparam logic [IDX_W-1:0] REG_CENTURY   = 7'h32;

	localparam logic [CTL_AW-1:0] CA_SEC      = 4'h0;
	localparam logic [CTL_AW-1:0] CA_SEC_ALM  = 4'h1;
	localparam logic [CTL_AW-1:0] CA_MIN      = 4'h2;
	localparam logic [CTL_AW-1:0] CA_MIN_ALM  = 4'h3;
	localparam logic [CTL_AW-1:0] CA_HOUR     = 4'h4;
	localparam logic [CTL_AW-1:0] CA_HOUR_ALM = 4'h5;
	localparam logic [CTL_AW-1:0] CA_A        = 4'hA;
	localparam logic [CTL_AW-1:0] CA_B        = 4'hB;
	localparam logic [CTL_AW-1:0] CA_C        = 4'hC;
	localparam logic [CTL_AW-1:0] CA_D        = 4'hD;

	// Register bit positions
	localparam int A_UIP  = 7;
	localparam int B_SET  = 7;
	localparam int B_PIE  = 6;
	localparam int B_AIE  = 5;
	localparam int B_UIE  = 4;
	localparam int C_IRQF = 7;
	localparam int C_PF   = 6;
	localparam int C_AF   = 5;
	localparam int C_UF   = 4;
	localparam int D_VRT  = 7;

	localparam logic [7:0] ALARM_ANY   = 8'hC0;
	localparam logic [7:0] NO_RAM_DATA = 8'hFF;

	// Write request into the NVRAM array
	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} nv_wr_t;

	// Alarm byte matches its time byte, or holds the don't-care code
	function automatic logic alarm_hit(logic [7:0] t, logic [7:0] a);
		return (a == t) || ((a & ALARM_ANY) == ALARM_ANY);
	endfunction

endpackage

`default_nettype wire

@@ design/crb_ifs.sv @@
// Valid/ready channel interfaces: request, response and configuration write.
`default_nettype none

interface crb_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic       port_select;
	logic [7:0] write_data;
	modport source (output valid, output mode, output port_select, output write_data,
		input ready);
	modport sink (input valid, input mode, input port_select, input write_data,
		output ready);
endinterface

interface crb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       irq_line;
	logic       nmi_enabled;
	logic       save_needed;
	logic       time_byte_written;
	modport source (output valid, output read_data, output irq_line, output nmi_enabled,
		output save_needed, output time_byte_written, input ready);
	modport sink (input valid, input read_data, input irq_line, input nmi_enabled,
		input save_needed, input time_byte_written, output ready);
endinterface

interface crb_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [crb_pkg::CFG_IDX_W-1:0]  index;
	logic [crb_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/crb_nvram.sv @@
// NVRAM byte array above the clock registers, with reset-valid bits and a tracked read.
`default_nettype none

module crb_nvram (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire crb_pkg::nv_wr_t            wr,
	input  wire logic [crb_pkg::MEM_AW-1:0] rd_addr,
	output logic [7:0]                      rd_data
);

	logic [7:0]                    mem [crb_pkg::MEM_DEPTH];
	logic [crb_pkg::MEM_DEPTH-1:0] vld_q;
	logic [7:0]                    rd_raw_q;
	logic [7:0]                    fwd_data_q;
	logic                          rd_ok_q;
	logic                          fwd_q;

	// Store writes, read the selected entry every cycle
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_raw_q <= mem[rd_addr];
	end

	// Hold the last written byte for the cycle after the write
	always_ff @(posedge clk) begin
		if (wr.en) begin
			fwd_data_q <= wr.data;
		end
	end

	// Track which entries were written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rd_ok_q <= 1'b0;
			fwd_q   <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rd_ok_q <= vld_q[rd_addr];
			fwd_q   <= wr.en;
		end
	end

	// Never-written entries read as zero; a fresh write wins over the stale read
	assign rd_data = fwd_q ? fwd_data_q : (rd_ok_q ? rd_raw_q : 8'h00);

endmodule

`default_nettype wire

@@ design/cmos_rtc_register_block_top.sv @@
// Top level of the CMOS clock and NVRAM register block.
// Usage:
//  req carries one transaction per item: a port read or write on the index port
//  or the data port, a periodic base tick, a centisecond tick or an update-end event.
//  rsp returns exactly one result per request: read byte (zero unless a port read),
//  interrupt level, NMI enable, sticky save mark and the time-byte-written pulse.
//  cfg writes the index mask, the NMI update enable and the time sync flag; write
//  it only while no request is in flight. cfg is always ready.
//  Result: the result of an accepted request is held in the result register.
//  Throughput: one request per cycle when not stalled; all register updates for an
//  item are done by one read-modify-write pass from the state registers into the
//  result register. The NVRAM read for the selected index is prefetched whenever the
//  index changes, so data port accesses find the byte already read.
//  Stall: while rsp.ready is low and a result is held, req.ready drops; a new
//  request is taken in the same cycle the held result leaves.
//  Reset (arst_n low): registers (bar VRT) and RAM read as zero, index mask 63, NMI
//  update enable on, time sync off, no result pending. No clearing pass is needed.
`default_nettype none

module cmos_rtc_register_block_top (
	input wire logic  clk,
	input wire logic  arst_n,
	crb_req_if.sink   req,
	crb_rsp_if.source rsp,
	crb_cfg_if.sink   cfg
);

	// Configuration registers
	logic [6:0] idx_mask_q;
	logic       nmi_upd_q;
	logic       tsync_q;

	// Clock and status state
	logic [7:0]                    ctl_q [crb_pkg::CTL_COUNT];
	logic [7:0]                    ctl_d [crb_pkg::CTL_COUNT];
	logic [crb_pkg::IDX_W-1:0]     cur_idx_q, cur_idx_d;
	logic [14:0]                   per_cnt_q, per_cnt_d;
	logic [6:0]                    cs_cnt_q, cs_cnt_d;
	logic                          uip_q, uip_d;
	logic                          pend_q, pend_d;
	logic                          irq_q, irq_d;
	logic                          nmi_q, nmi_d;
	logic                          save_q, save_d;

	// Result register
	logic       out_vld_q;
	logic [7:0] out_rd_q;
	logic       out_irq_q;
	logic       out_nmi_q;
	logic       out_save_q;
	logic       out_pulse_q;

	// Step logic
	logic                          accept;
	logic [7:0]                    rd_val;
	logic                          pulse;
	logic [7:0]                    old_val;
	logic [7:0]                    nv_rdata;
	logic                          in_ram;
	logic                          is_ctl;
	logic [crb_pkg::CTL_AW-1:0]    ctl_ix;
	logic [3:0]                    rate;
	logic [14:0]                   per_inc;
	logic [15:0]                   per_thr;
	logic [6:0]                    cs_inc;
	logic                          alarm_ok;
	logic                          nxt_in_mem;
	crb_pkg::nv_wr_t               nv_wr;
	logic [crb_pkg::MEM_AW-1:0]    nv_raddr;

	assign accept    = req.valid && req.ready;
	assign req.ready = !out_vld_q || rsp.ready;
	assign cfg.ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_mask_q <= 7'd63;
			nmi_upd_q  <= 1'b1;
			tsync_q    <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				crb_pkg::CFG_INDEX_MASK: idx_mask_q <= cfg.data[6:0];
				crb_pkg::CFG_NMI_UPDATE: nmi_upd_q  <= cfg.data[0];
				crb_pkg::CFG_TIME_SYNC:  tsync_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Decode the selected register
	assign in_ram  = {1'b0, cur_idx_q} < crb_pkg::RAM_DEPTH_X;
	assign is_ctl  = cur_idx_q < crb_pkg::CTL_COUNT_IDX;
	assign ctl_ix  = is_ctl ? cur_idx_q[crb_pkg::CTL_AW-1:0] : '0;
	assign old_val = is_ctl ? ctl_q[ctl_ix] : nv_rdata;

	// Divider and tick arithmetic
	assign rate    = ctl_q[crb_pkg::CA_A][3:0];
	assign per_inc = per_cnt_q + 15'd1;
	assign per_thr = 16'd1 << (rate - 4'd1);
	assign cs_inc  = cs_cnt_q + 7'd1;

	assign alarm_ok =
		crb_pkg::alarm_hit(ctl_q[crb_pkg::CA_SEC],  ctl_q[crb_pkg::CA_SEC_ALM]) &&
		crb_pkg::alarm_hit(ctl_q[crb_pkg::CA_MIN],  ctl_q[crb_pkg::CA_MIN_ALM]) &&
		crb_pkg::alarm_hit(ctl_q[crb_pkg::CA_HOUR], ctl_q[crb_pkg::CA_HOUR_ALM]);

	// Apply one transaction to the state
	always_comb begin
		ctl_d     = ctl_q;
		cur_idx_d = cur_idx_q;
		per_cnt_d = per_cnt_q;
		cs_cnt_d  = cs_cnt_q;
		uip_d     = uip_q;
		pend_d    = pend_q;
		irq_d     = irq_q;
		nmi_d     = nmi_q;
		save_d    = save_q;
		rd_val    = 8'h00;
		pulse     = 1'b0;
		nv_wr     = '0;
		if (accept) begin
			case (req.mode)
				crb_pkg::MODE_PORT_READ: begin
					if (!req.port_select) begin
						rd_val = {1'b0, cur_idx_q};
					end else if (!in_ram) begin
						rd_val = crb_pkg::NO_RAM_DATA;
					end else if (cur_idx_q == crb_pkg::REG_A) begin
						rd_val = {uip_q, ctl_q[crb_pkg::CA_A][6:0]};
					end else if (cur_idx_q == crb_pkg::REG_C) begin
						rd_val                  = ctl_q[crb_pkg::CA_C];
						ctl_d[crb_pkg::CA_C]    = 8'h00;
						irq_d                   = 1'b0;
					end else if (cur_idx_q == crb_pkg::REG_D) begin
						rd_val                            = ctl_q[crb_pkg::CA_D];
						rd_val[crb_pkg::D_VRT]            = 1'b1;
						ctl_d[crb_pkg::CA_D][crb_pkg::D_VRT] = 1'b1;
					end else begin
						rd_val = old_val;
					end
				end
				crb_pkg::MODE_PORT_WRITE: begin
					if (!req.port_select) begin
						cur_idx_d = req.write_data[6:0] & idx_mask_q;
						if (nmi_upd_q) begin
							nmi_d = !req.write_data[7];
						end
					end else if (in_ram && cur_idx_q != crb_pkg::REG_C &&
						cur_idx_q != crb_pkg::REG_D) begin
						if (cur_idx_q > crb_pkg::REG_D && old_val != req.write_data) begin
							save_d = 1'b1;
						end
						if (is_ctl) begin
							ctl_d[ctl_ix] = req.write_data;
						end else begin
							nv_wr.en   = 1'b1;
							nv_wr.addr = crb_pkg::MEM_AW'(cur_idx_q - crb_pkg::CTL_COUNT_IDX);
							nv_wr.data = req.write_data;
						end
						if (cur_idx_q == crb_pkg::REG_A) begin
							per_cnt_d = '0;
						end
						// Entering SET mode stops the update cycle
						if (cur_idx_q == crb_pkg::REG_B && !old_val[crb_pkg::B_SET] &&
							req.write_data[crb_pkg::B_SET]) begin
							ctl_d[crb_pkg::CA_A][crb_pkg::A_UIP] = 1'b0;
							ctl_d[crb_pkg::CA_B][crb_pkg::B_UIE] = 1'b0;
						end
						// Flag a changed time or century byte
						if ((cur_idx_q < crb_pkg::REG_A || cur_idx_q == crb_pkg::REG_CENTURY) &&
							cur_idx_q != crb_pkg::REG_SEC_ALM &&
							cur_idx_q != crb_pkg::REG_MIN_ALM &&
							cur_idx_q != crb_pkg::REG_HOUR_ALM &&
							old_val != req.write_data && !tsync_q) begin
							pulse  = 1'b1;
							save_d = 1'b1;
						end
					end
				end
				crb_pkg::MODE_PERIODIC: begin
					if (rate == 4'd0) begin
						per_cnt_d = '0;
					end else if ({1'b0, per_inc} >= per_thr) begin
						per_cnt_d                            = '0;
						ctl_d[crb_pkg::CA_C][crb_pkg::C_PF] = 1'b1;
						if (ctl_q[crb_pkg::CA_B][crb_pkg::B_PIE]) begin
							ctl_d[crb_pkg::CA_C][crb_pkg::C_IRQF] = 1'b1;
							irq_d                                 = 1'b1;
						end
					end else begin
						per_cnt_d = per_inc;
					end
				end
				crb_pkg::MODE_CENTI_TICK: begin
					if (cs_inc >= crb_pkg::TICKS_LIMIT) begin
						cs_cnt_d = '0;
						if (!ctl_q[crb_pkg::CA_B][crb_pkg::B_SET]) begin
							uip_d  = 1'b1;
							pend_d = 1'b1;
						end
					end else begin
						cs_cnt_d = cs_inc;
					end
				end
				crb_pkg::MODE_UPDATE_END: begin
					if (pend_q) begin
						pend_d = 1'b0;
						if (!ctl_q[crb_pkg::CA_B][crb_pkg::B_SET]) begin
							uip_d = 1'b0;
							if (alarm_ok) begin
								ctl_d[crb_pkg::CA_C][crb_pkg::C_AF] = 1'b1;
								if (ctl_q[crb_pkg::CA_B][crb_pkg::B_AIE]) begin
									ctl_d[crb_pkg::CA_C][crb_pkg::C_IRQF] = 1'b1;
									irq_d                                 = 1'b1;
								end
							end
							ctl_d[crb_pkg::CA_C][crb_pkg::C_UF] = 1'b1;
							if (ctl_q[crb_pkg::CA_B][crb_pkg::B_UIE]) begin
								ctl_d[crb_pkg::CA_C][crb_pkg::C_IRQF] = 1'b1;
								irq_d                                 = 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Prefetch the NVRAM byte at the index that holds after this cycle
	assign nxt_in_mem = cur_idx_d >= crb_pkg::CTL_COUNT_IDX &&
		{1'b0, cur_idx_d} < crb_pkg::RAM_DEPTH_X;
	assign nv_raddr = nxt_in_mem ?
		crb_pkg::MEM_AW'(cur_idx_d - crb_pkg::CTL_COUNT_IDX) : '0;

	crb_nvram u_nvram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (nv_wr),
		.rd_addr (nv_raddr),
		.rd_data (nv_rdata)
	);

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < crb_pkg::CTL_COUNT; i++) begin
				ctl_q[i] <= 8'h00;
			end
			cur_idx_q <= '0;
			per_cnt_q <= '0;
			cs_cnt_q  <= '0;
			uip_q     <= 1'b0;
			pend_q    <= 1'b0;
			irq_q     <= 1'b0;
			nmi_q     <= 1'b0;
			save_q    <= 1'b0;
		end else begin
			ctl_q     <= ctl_d;
			cur_idx_q <= cur_idx_d;
			per_cnt_q <= per_cnt_d;
			cs_cnt_q  <= cs_cnt_d;
			uip_q     <= uip_d;
			pend_q    <= pend_d;
			irq_q     <= irq_d;
			nmi_q     <= nmi_d;
			save_q    <= save_d;
		end
	end

	// Result valid: set on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_rd_q    <= rd_val;
			out_irq_q   <= irq_d;
			out_nmi_q   <= nmi_d;
			out_save_q  <= save_d;
			out_pulse_q <= pulse;
		end
	end

	assign rsp.valid             = out_vld_q;
	assign rsp.read_data         = out_rd_q;
	assign rsp.irq_line          = out_irq_q;
	assign rsp.nmi_enabled       = out_nmi_q;
	assign rsp.save_needed       = out_save_q;
	assign rsp.time_byte_written = out_pulse_q;

endmodule

`default_nettype wire

@@ design/crb_checker.sv @@
// Port-level assertions for the register block, bound to the top level.
`default_nettype none

module crb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic [2:0] req_mode,
	input wire logic       req_port_select,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [7:0] rsp_read_data,
	input wire logic       rsp_save_needed,
	input wire logic       rsp_time_byte_written
);

	logic req_take;

	assign req_take = req_valid && req_ready;

	// A result waits until it is taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// Only port reads return data
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && req_mode != crb_pkg::MODE_PORT_READ |=> rsp_valid && rsp_read_data == 8'h00)
		else $error("nonzero read data on a non-read transaction");

	// Time write pulse only follows a data port write
	a_pulse_src: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && !(req_mode == crb_pkg::MODE_PORT_WRITE && req_port_select)
		|=> !rsp_time_byte_written)
		else $error("time write pulse without a data write");

	// Save mark is sticky
	a_save_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_save_needed |=> !rsp_valid || rsp_save_needed)
		else $error("save mark cleared");

	// Free result slot means requests are taken
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("request stalled while response side is ready");

endmodule

bind cmos_rtc_register_block_top crb_checker u_crb_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.req_valid             (req.valid),
	.req_ready             (req.ready),
	.req_mode              (req.mode),
	.req_port_select       (req.port_select),
	.rsp_valid             (rsp.valid),
	.rsp_ready             (rsp.ready),
	.rsp_read_data         (rsp.read_data),
	.rsp_save_needed       (rsp.save_needed),
	.rsp_time_byte_written (rsp.time_byte_written)
);

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the CMOS clock and NVRAM register block.
`timescale 1ns / 100ps

module tb;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int SEGMENT_ITEMS  = 236;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 4;

	// Unused transaction kinds, ignored by the block
	localparam logic [2:0] MODE_RSVD5 = 3'd5;
	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;

	localparam logic PORT_INDEX = 1'b0;
	localparam logic PORT_DATA  = 1'b1;

	// Configuration index with no register behind it
	localparam logic [crb_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_line;
		logic       nmi_enabled;
		logic       save_needed;
		logic       time_byte_written;
	} rtc_status_t;

	// Shadow copy of the register block; predicts the status of each access
	class cmos_rtc_shadow;
		logic [7:0]  nvram [crb_pkg::RAM_DEPTH];
		logic [6:0]  cur_index;
		logic [14:0] div_count;
		logic [6:0]  centi_count;
		logic        uip;
		logic        upd_pending;
		logic        irq;
		logic        nmi_en;
		logic        save_mark;
		logic [6:0]  index_mask;
		logic        nmi_update;
		logic        time_sync;
		rtc_status_t due_status[$];
		int          errors;
		int          matched;
		int          periodic_fires;
		int          updates_done;
		int          alarm_hits;

		function new();
			foreach (nvram[i]) nvram[i] = 8'h00;
			cur_index      = '0;
			div_count      = '0;
			centi_count    = '0;
			uip            = 1'b0;
			upd_pending    = 1'b0;
			irq            = 1'b0;
			nmi_en         = 1'b0;
			save_mark      = 1'b0;
			index_mask     = 7'd63;
			nmi_update     = 1'b1;
			time_sync      = 1'b0;
			errors         = 0;
			matched        = 0;
			periodic_fires = 0;
			updates_done   = 0;
			alarm_hits     = 0;
		endfunction

		function void set_config(logic [crb_pkg::CFG_IDX_W-1:0] ix,
				logic [crb_pkg::CFG_DATA_W-1:0] val);
			case (ix)
				crb_pkg::CFG_INDEX_MASK: index_mask = val;
				crb_pkg::CFG_NMI_UPDATE: nmi_update = val[0];
				crb_pkg::CFG_TIME_SYNC:  time_sync  = val[0];
				default: ;
			endcase
		endfunction

		// Set a status flag in C; assert the interrupt if its enable in B is on
		function void raise_flag(int flag, int enable);
			nvram[crb_pkg::REG_C][flag] = 1'b1;
			if (nvram[crb_pkg::REG_B][enable]) begin
				nvram[crb_pkg::REG_C][crb_pkg::C_IRQF] = 1'b1;
				irq = 1'b1;
			end
		endfunction

		function logic alarm_ok(int t);
			logic [7:0] a;
			a = nvram[t + 1];
			return (a == nvram[t]) || ((a & crb_pkg::ALARM_ANY) == crb_pkg::ALARM_ANY);
		endfunction

		function logic [7:0] read_selected();
			logic [7:0] v;
			if (cur_index == crb_pkg::REG_A)
				return {uip, nvram[crb_pkg::REG_A][6:0]};
			if (cur_index == crb_pkg::REG_D)
				nvram[crb_pkg::REG_D][crb_pkg::D_VRT] = 1'b1;
			if (cur_index == crb_pkg::REG_C) begin
				irq = 1'b0;
				v = nvram[crb_pkg::REG_C];
				nvram[crb_pkg::REG_C] = 8'h00;
				return v;
			end
			return nvram[cur_index];
		endfunction

		// Store a data port byte; return the time-byte pulse
		function logic write_selected(logic [7:0] val);
			logic [7:0] old;
			logic       pulse;
			pulse = 1'b0;
			if (cur_index == crb_pkg::REG_C || cur_index == crb_pkg::REG_D)
				return 1'b0;
			old = nvram[cur_index];
			if (cur_index > crb_pkg::REG_D && old != val)
				save_mark = 1'b1;
			nvram[cur_index] = val;
			if (cur_index == crb_pkg::REG_A) begin
				div_count = '0;
				return 1'b0;
			end
			if (cur_index == crb_pkg::REG_B && (old[crb_pkg::B_SET] ^ val[crb_pkg::B_SET])
					&& val[crb_pkg::B_SET]) begin
				nvram[crb_pkg::REG_A][crb_pkg::A_UIP] = 1'b0;
				nvram[crb_pkg::REG_B][crb_pkg::B_UIE] = 1'b0;
			end
			if ((cur_index < crb_pkg::REG_A || cur_index == crb_pkg::REG_CENTURY)
					&& cur_index != crb_pkg::REG_SEC_ALM
					&& cur_index != crb_pkg::REG_MIN_ALM
					&& cur_index != crb_pkg::REG_HOUR_ALM) begin
				if (old != val && !time_sync) begin
					pulse = 1'b1;
					save_mark = 1'b1;
				end
			end
			return pulse;
		endfunction

		function void periodic_tick();
			int rate;
			rate = nvram[crb_pkg::REG_A][3:0];
			if (rate == 0) begin
				div_count = '0;
				return;
			end
			div_count = div_count + 15'd1;
			if (int'(div_count) >= (1 << (rate - 1))) begin
				div_count = '0;
				periodic_fires++;
				raise_flag(crb_pkg::C_PF, crb_pkg::B_PIE);
			end
		endfunction

		function void centi_tick();
			centi_count = centi_count + 7'd1;
			if (int'(centi_count) >= crb_pkg::TICKS_PER_UPDATE) begin
				if (!nvram[crb_pkg::REG_B][crb_pkg::B_SET]) begin
					uip = 1'b1;
					upd_pending = 1'b1;
				end
				centi_count = '0;
			end
		endfunction

		function void end_update();
			if (!upd_pending)
				return;
			upd_pending = 1'b0;
			if (nvram[crb_pkg::REG_B][crb_pkg::B_SET])
				return;
			uip = 1'b0;
			updates_done++;
			if (alarm_ok(crb_pkg::REG_SEC) && alarm_ok(crb_pkg::REG_MIN)
					&& alarm_ok(crb_pkg::REG_HOUR)) begin
				alarm_hits++;
				raise_flag(crb_pkg::C_AF, crb_pkg::B_AIE);
			end
			raise_flag(crb_pkg::C_UF, crb_pkg::B_UIE);
		endfunction

		// Apply one accepted access and queue the status it must produce
		function void take_access(logic [2:0] mode, logic port, logic [7:0] wdata);
			rtc_status_t s;
			s = '0;
			case (mode)
				crb_pkg::MODE_PORT_READ:
					s.read_data = port ? read_selected() : {1'b0, cur_index};
				crb_pkg::MODE_PORT_WRITE:
					if (port) begin
						s.time_byte_written = write_selected(wdata);
					end else begin
						cur_index = wdata[6:0] & index_mask;
						if (nmi_update)
							nmi_en = ~wdata[7];
					end
				crb_pkg::MODE_PERIODIC:   periodic_tick();
				crb_pkg::MODE_CENTI_TICK: centi_tick();
				crb_pkg::MODE_UPDATE_END: end_update();
				default: ;
			endcase
			s.irq_line    = irq;
			s.nmi_enabled = nmi_en;
			s.save_needed = save_mark;
			due_status.push_back(s);
		endfunction

		function void compare(string field, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_status(rtc_status_t got);
			rtc_status_t want;
			if (due_status.size() == 0) begin
				errors++;
				$display("%0t: status with no access waiting, expected none actual %h",
					$time, got);
				return;
			end
			want = due_status.pop_front();
			compare("read_data", want.read_data, got.read_data);
			compare("irq_line", 8'(want.irq_line), 8'(got.irq_line));
			compare("nmi_enabled", 8'(want.nmi_enabled), 8'(got.nmi_enabled));
			compare("save_needed", 8'(want.save_needed), 8'(got.save_needed));
			compare("time_byte_written", 8'(want.time_byte_written),
				8'(got.time_byte_written));
			matched++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle;
	int   recv_idle;
	int   items_sent;
	int   cfg_writes;
	logic hold_req;
	logic any_xfer;

	cmos_rtc_shadow shadow = new();

	crb_req_if req();
	crb_rsp_if rsp();
	crb_cfg_if cfg();

	cmos_rtc_register_block_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	assign any_xfer = (req.valid && req.ready) || (rsp.valid && rsp.ready)
		|| (cfg.valid && cfg.ready);

	// Track every transaction on the three channels
	always @(posedge clk) begin
		if (cfg.valid && cfg.ready)
			shadow.set_config(cfg.index, cfg.data);
		if (rsp.valid && rsp.ready)
			shadow.check_status(rtc_status_t'{read_data: rsp.read_data,
				irq_line: rsp.irq_line, nmi_enabled: rsp.nmi_enabled,
				save_needed: rsp.save_needed, time_byte_written: rsp.time_byte_written});
		if (req.valid && req.ready)
			shadow.take_access(req.mode, req.port_select, req.write_data);
	end

	// Drive rsp.ready; hold it low for a long stretch on request
	initial begin : rsp_sink
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			rsp.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Abort when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (any_xfer)
				quiet = 0;
			else
				quiet++;
		end
		$display("cmos_rtc_register_block_top: mismatch");
		$finish;
	end

	// Offer one access, with random idle cycles ahead of it
	task automatic send_item(input logic [2:0] mode, input logic port, input logic [7:0] wdata);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid       <= 1'b1;
		req.mode        <= mode;
		req.port_select <= port;
		req.write_data  <= wdata;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (mode <= crb_pkg::MODE_UPDATE_END)
			items_sent++;
	endtask

	// Drain the block, then write one configuration register
	task automatic cfg_write(input logic [crb_pkg::CFG_IDX_W-1:0] ix,
			input logic [crb_pkg::CFG_DATA_W-1:0] val);
		req.valid <= 1'b0;
		@(posedge clk);
		while (shadow.due_status.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= ix;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		cfg_writes++;
	endtask

	task automatic configure(input logic [6:0] mask, input logic [6:0] nmi,
			input logic [6:0] sync);
		cfg_write(crb_pkg::CFG_INDEX_MASK, mask);
		cfg_write(crb_pkg::CFG_NMI_UPDATE, nmi);
		cfg_write(crb_pkg::CFG_TIME_SYNC, sync);
	endtask

	// Favor time, alarm and control registers over plain RAM
	function automatic logic [6:0] pick_index();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return 7'($urandom_range(5));
		if (r < 60)
			return crb_pkg::REG_A + 7'($urandom_range(3));
		if (r < 65)
			return crb_pkg::REG_CENTURY;
		return 7'($urandom_range(127));
	endfunction

	function automatic logic [7:0] pick_value(input logic [6:0] ix);
		int r;
		r = $urandom_range(99);
		if (ix == crb_pkg::REG_A)
			return {4'($urandom_range(15)), (r < 80) ? 4'($urandom_range(4)) :
				4'($urandom_range(15))};
		if (ix == crb_pkg::REG_B)
			return {($urandom_range(99) < 25) ? 1'b1 : 1'b0, 7'($urandom_range(127))};
		if (ix <= crb_pkg::REG_HOUR_ALM) begin
			if (r < 30)
				return crb_pkg::ALARM_ANY | 8'($urandom_range(63));
			if (r < 70)
				return 8'($urandom_range(3));
		end
		return 8'($urandom_range(255));
	endfunction

	// Random traffic: mostly index-then-data sequences and tick bursts
	task automatic run_segment(input int count);
		int          stop;
		int          r;
		logic [6:0]  ix;
		stop = items_sent + count;
		while (items_sent < stop) begin
			r = $urandom_range(99);
			if (r < 35) begin
				ix = pick_index();
				send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX, {1'($urandom_range(1)), ix});
				repeat ($urandom_range(3, 1)) begin
					if ($urandom_range(1))
						send_item(crb_pkg::MODE_PORT_READ, PORT_DATA,
							8'($urandom_range(255)));
					else
						send_item(crb_pkg::MODE_PORT_WRITE, PORT_DATA, pick_value(ix));
				end
			end else if (r < 48) begin
				repeat ($urandom_range(8, 1))
					send_item(crb_pkg::MODE_PERIODIC, 1'($urandom_range(1)),
						8'($urandom_range(255)));
			end else if (r < 63) begin
				repeat ($urandom_range(60, 10))
					send_item(crb_pkg::MODE_CENTI_TICK, 1'($urandom_range(1)),
						8'($urandom_range(255)));
				if ($urandom_range(1))
					send_item(crb_pkg::MODE_UPDATE_END, 1'($urandom_range(1)),
						8'($urandom_range(255)));
			end else if (r < 71) begin
				send_item(crb_pkg::MODE_UPDATE_END, 1'($urandom_range(1)),
					8'($urandom_range(255)));
			end else if (r < 80) begin
				send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX,
					{1'($urandom_range(1)), crb_pkg::REG_C});
				send_item(crb_pkg::MODE_PORT_READ, PORT_DATA, 8'($urandom_range(255)));
			end else if (r < 88) begin
				send_item(crb_pkg::MODE_PORT_READ, PORT_INDEX, 8'($urandom_range(255)));
			end else begin
				send_item(3'($urandom_range(7)), 1'($urandom_range(1)), 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin : main
		int ph;
		int half;
		req.valid       <= 1'b0;
		req.mode        <= crb_pkg::MODE_PORT_READ;
		req.port_select <= PORT_INDEX;
		req.write_data  <= 8'h00;
		cfg.valid       <= 1'b0;
		cfg.index       <= crb_pkg::CFG_INDEX_MASK;
		cfg.data        <= '0;
		arst_n          <= 1'b0;
		send_idle  = 0;
		recv_idle  = 0;
		items_sent = 0;
		cfg_writes = 0;
		hold_req   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values, sync suppression, masking, control registers
		cfg_write(CFG_SPARE, 7'h55);
		send_item(crb_pkg::MODE_PORT_READ, PORT_INDEX, 8'h00);
		send_item(crb_pkg::MODE_PORT_READ, PORT_DATA, 8'hFF);
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX, 8'h20);
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_DATA, 8'h00);
		send_item(crb_pkg::MODE_UPDATE_END, PORT_INDEX, 8'h00);
		cfg_write(crb_pkg::CFG_TIME_SYNC, 7'h01);
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX, 8'h80);
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_DATA, 8'h15);
		cfg_write(crb_pkg::CFG_TIME_SYNC, 7'h00);
		cfg_write(crb_pkg::CFG_NMI_UPDATE, 7'h00);
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX, {1'b0, crb_pkg::REG_CENTURY});
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_DATA, 8'hFF);
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX, 8'h7F);
		send_item(crb_pkg::MODE_PORT_READ, PORT_INDEX, 8'h00);
		cfg_write(crb_pkg::CFG_INDEX_MASK, 7'h7F);
		cfg_write(crb_pkg::CFG_NMI_UPDATE, 7'h01);
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX, 8'hFF);
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_DATA, 8'hAA);
		send_item(crb_pkg::MODE_PORT_READ, PORT_DATA, 8'h00);
		// Rate one with a stored bit 7 in A, then the periodic flag with and without PIE
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX, {1'b0, crb_pkg::REG_A});
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_DATA, 8'h81);
		send_item(crb_pkg::MODE_PORT_READ, PORT_DATA, 8'h00);
		send_item(crb_pkg::MODE_PERIODIC, PORT_INDEX, 8'h00);
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX, {1'b0, crb_pkg::REG_B});
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_DATA, 8'h40);
		send_item(crb_pkg::MODE_PERIODIC, PORT_DATA, 8'hFF);
		// C ignores writes and clears on read; D reads back VRT
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX, {1'b0, crb_pkg::REG_C});
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_DATA, 8'h00);
		send_item(crb_pkg::MODE_PORT_READ, PORT_DATA, 8'h00);
		send_item(crb_pkg::MODE_PORT_READ, PORT_DATA, 8'h00);
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX, {1'b0, crb_pkg::REG_D});
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_DATA, 8'h00);
		send_item(crb_pkg::MODE_PORT_READ, PORT_DATA, 8'h00);
		// SET rising clears UIE; rate zero stops the divider
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX, {1'b0, crb_pkg::REG_B});
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_DATA, 8'hD0);
		send_item(crb_pkg::MODE_PORT_READ, PORT_DATA, 8'h00);
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_INDEX, {1'b0, crb_pkg::REG_A});
		send_item(crb_pkg::MODE_PORT_WRITE, PORT_DATA, 8'h00);
		send_item(crb_pkg::MODE_PERIODIC, PORT_INDEX, 8'h00);
		send_item(MODE_RSVD5, PORT_INDEX, 8'h00);
		send_item(MODE_RSVD6, PORT_DATA, 8'hFF);
		send_item(MODE_RSVD7, PORT_INDEX, 8'h5A);

		// Random: three idle profiles, two settings each
		for (ph = 0; ph < 3; ph++) begin
			for (half = 0; half < 2; half++) begin
				case (ph * 2 + half)
					0: configure(7'd127, 7'd1, 7'd0);
					1: configure(7'd63, 7'd0, 7'd1);
					2: configure(7'd0, 7'd1, 7'd0);
					3: configure(7'd127, 7'd0, 7'd0);
					4: configure(7'($urandom_range(127)), 7'($urandom_range(127)),
						7'($urandom_range(127)));
					default: configure(7'd127, 7'd1, 7'd0);
				endcase
				send_idle = (ph == 0) ? 23 : (ph == 1) ? 58 : 0;
				recv_idle = (ph == 0) ? 58 : (ph == 1) ? 23 : 0;
				if (ph == 2 && half == 0)
					hold_req = 1'b1;
				run_segment(SEGMENT_ITEMS);
			end
		end

		// Drain and report
		req.valid <= 1'b0;
		@(posedge clk);
		while (shadow.due_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d accesses, %0d statuses checked, %0d config writes",
			items_sent, shadow.matched, cfg_writes);
		$display("with %0d periodic interrupts, %0d update cycles and %0d alarm hits",
			shadow.periodic_fires, shadow.updates_done, shadow.alarm_hits);
		if (shadow.errors == 0)
			$display("cmos_rtc_register_block_top: match");
		else
			$display("cmos_rtc_register_block_top: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
design/crb_pkg.sv
design/crb_ifs.sv
design/crb_nvram.sv
design/cmos_rtc_register_block_top.sv
design/crb_checker.sv
dv/tb.sv
